// ----- hdl/sacl_pkg.sv -----
// Shared constants and types of the set-associative LRU cache tag model.
`timescale 1ns / 1ps

package sacl_pkg;

  // Address and result field widths.
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int OUTCOME_W = 2;
  localparam int WAY_OUT_W = 3;

  // Default sizes of the line storage.
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int AGE_WIDTH_DEF    = 16;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int SIB_W      = 3;
  localparam int BOB_W      = 4;
  localparam int WAYS_W     = 4;

  localparam logic [SIB_W-1:0]  SIB_RESET  = 3'd4;
  localparam logic [BOB_W-1:0]  BOB_RESET  = 4'd4;
  localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } reg_idx_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

endpackage

// ----- hdl/sacl_if.sv -----
// Valid/ready channel interfaces for the cache model access and result streams.
`timescale 1ns / 1ps

interface sacl_req_if;
  import sacl_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink   (input valid, input op, input address, output ready);
endinterface

interface sacl_rsp_if;
  import sacl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [WAY_OUT_W-1:0] way_used;
  logic                 is_last;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;
  logic [CNT_W-1:0]     eviction_total;

  modport source (output valid, output outcome, output way_used, output is_last,
                  output hit_total, output miss_total, output eviction_total,
                  input ready);
  modport sink   (input valid, input outcome, input way_used, input is_last,
                  input hit_total, input miss_total, input eviction_total,
                  output ready);
endinterface

// ----- hdl/sacl_tag_store.sv -----
// Row memory holding one set of lines per entry, with a clearing pass after reset.
`timescale 1ns / 1ps

module sacl_tag_store #(
  parameter int IDX_W = 1,
  parameter int ROW_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i,
  output logic             busy_o
);

  localparam int DEPTH = 1 << IDX_W;

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rd_data_q;
  logic             busy_q, busy_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  // The clearing pass owns the write port until every row is zeroed.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_comb begin
    busy_d    = busy_q;
    clr_idx_d = clr_idx_q;
    if (busy_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == {IDX_W{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

// ----- hdl/set_assoc_cache_lru_model_core.sv -----
// Top level of the set-associative cache tag model with LRU replacement.
//
// Accesses enter on req_i (op, address); results leave on rsp_o, one per access:
// a load or store (op 0) gives one result, a modify (op 1) gives two, the second
// marked is_last. Each result carries the outcome, the way used and the running
// hit, miss and eviction totals after that access.
// Configuration registers sit on the APB port at byte addresses 0, 4 and 8:
// set index bits, block offset bits and ways in use. Write them only while idle.
// One access reads the set's row, then a single tag/age comparator walks the
// ways one per cycle, then the row is written back. A new access is accepted
// only after the final write-back of the previous one; a modify scans and
// writes back the row twice. After reset the row memory is cleared one set per
// cycle and req_i.ready stays low until that pass ends.
// The result sits in an output register, so a new item is accepted while it waits.
// A stalled receiver only holds up the row write-back of the next access.
`timescale 1ns / 1ps

module set_assoc_cache_lru_model_core #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int AGE_WIDTH    = sacl_pkg::AGE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sacl_req_if.sink                            req_i,
  sacl_rsp_if.source                          rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sacl_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sacl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sacl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import sacl_pkg::*;

  localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_W-1:0]    tag;
    logic [AGE_WIDTH-1:0] age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  // Configuration registers.
  logic [SIB_W-1:0]  cfg_sib_q;
  logic [BOB_W-1:0]  cfg_bob_q;
  logic [WAYS_W-1:0] cfg_ways_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sib_q  <= SIB_RESET;
      cfg_bob_q  <= BOB_RESET;
      cfg_ways_q <= WAYS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SET_BITS:    cfg_sib_q  <= pwdata[SIB_W-1:0];
        REG_OFFSET_BITS: cfg_bob_q  <= pwdata[BOB_W-1:0];
        REG_WAYS:        cfg_ways_q <= pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SET_BITS:    prdata = APB_DATA_W'(cfg_sib_q);
      REG_OFFSET_BITS: prdata = APB_DATA_W'(cfg_bob_q);
      REG_WAYS:        prdata = APB_DATA_W'(cfg_ways_q);
      default:         prdata = '0;
    endcase
  end

  // Control and datapath registers.
  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [CNT_W-1:0]     hits_q, hits_d;
  logic [CNT_W-1:0]     misses_q, misses_d;
  logic [CNT_W-1:0]     evicts_q, evicts_d;
  logic [OUTCOME_W-1:0] out_outcome_q;
  logic [WAY_OUT_W-1:0] out_way_q;
  logic                 out_last_q;

  logic [ADDR_W-1:0]    tag_q;
  logic [SET_IDX_W-1:0] set_q;
  logic [WAY_IDX_W-1:0] way_last_q;
  logic [WAY_IDX_W-1:0] way_q;
  logic                 op_q;
  logic                 pass_q;
  logic                 hit_q, inv_q;
  logic [WAY_IDX_W-1:0] hit_way_q, inv_way_q, max_way_q;
  logic [AGE_WIDTH-1:0] max_age_q;
  row_t                 row_q;

  // Address split at acceptance.
  logic                 accept;
  logic [SIB_W-1:0]     sb_eff;
  logic [4:0]           tag_shamt;
  logic [ADDR_W-1:0]    acc_tag;
  logic [ADDR_W-1:0]    acc_offs;
  logic [SET_IDX_W-1:0] set_mask;
  logic [SET_IDX_W-1:0] acc_set;
  logic [WAY_IDX_W-1:0] acc_way_last;
  logic                 clr_busy;

  assign req_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    sb_eff    = (int'(cfg_sib_q) > MAX_SET_BITS) ? SIB_W'(MAX_SET_BITS) : cfg_sib_q;
    tag_shamt = 5'(sb_eff) + 5'(cfg_bob_q);
    acc_tag   = req_i.address >> tag_shamt;
    acc_offs  = req_i.address >> cfg_bob_q;
    set_mask  = ~({SET_IDX_W{1'b1}} << sb_eff);
    acc_set   = acc_offs[SET_IDX_W-1:0] & set_mask;
    if (cfg_ways_q == '0) begin
      acc_way_last = '0;
    end else if (int'(cfg_ways_q) > MAX_WAYS) begin
      acc_way_last = WAY_IDX_W'(MAX_WAYS - 1);
    end else begin
      acc_way_last = WAY_IDX_W'(cfg_ways_q - 1'b1);
    end
  end

  // Shared scan unit: one way per cycle.
  line_t                cur_line;
  logic [AGE_WIDTH-1:0] age_inc;
  logic                 tag_hit;

  always_comb begin
    cur_line = row_q[way_q];
    age_inc  = (cur_line.valid && (cur_line.age != {AGE_WIDTH{1'b1}}))
               ? cur_line.age + 1'b1 : cur_line.age;
    tag_hit  = cur_line.valid && (cur_line.tag == tag_q);
  end

  // Write-back of the chosen way.
  logic [WAY_IDX_W-1:0] chosen;
  outcome_e             outcome;
  row_t                 row_upd;
  logic                 out_free;
  logic                 commit;
  logic                 last_access;

  always_comb begin
    if (hit_q) begin
      chosen  = hit_way_q;
      outcome = OUT_HIT;
    end else if (inv_q) begin
      chosen  = inv_way_q;
      outcome = OUT_FILL;
    end else begin
      chosen  = max_way_q;
      outcome = OUT_EVICT;
    end
    row_upd               = row_q;
    row_upd[chosen].valid = 1'b1;
    row_upd[chosen].tag   = tag_q;
    row_upd[chosen].age   = '0;
  end

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign commit      = (state_q == S_WRITE) && out_free;
  assign last_access = !op_q || pass_q;

  logic [ROW_W-1:0] rd_row;

  sacl_tag_store #(
    .IDX_W (SET_IDX_W),
    .ROW_W (ROW_W)
  ) u_tag_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (acc_set),
    .rd_data_o (rd_row),
    .wr_en_i   (commit),
    .wr_addr_i (set_q),
    .wr_data_i (ROW_W'(row_upd)),
    .busy_o    (clr_busy)
  );

  // Sequencer and running totals.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    evicts_d    = evicts_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (way_q == way_last_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (commit) begin
          out_valid_d = 1'b1;
          state_d     = last_access ? S_IDLE : S_SCAN;
          if (hit_q) begin
            hits_d = (hits_q == '1) ? hits_q : hits_q + 1'b1;
          end else begin
            misses_d = (misses_q == '1) ? misses_q : misses_q + 1'b1;
            if (!inv_q) begin
              evicts_d = (evicts_q == '1) ? evicts_q : evicts_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q      <= acc_tag;
      set_q      <= acc_set;
      way_last_q <= acc_way_last;
      op_q       <= req_i.op;
      pass_q     <= 1'b0;
    end
    if (state_q == S_READ) begin
      row_q <= row_t'(rd_row);
      way_q <= '0;
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      row_q[way_q].age <= age_inc;
      if (!hit_q && tag_hit) begin
        hit_q     <= 1'b1;
        hit_way_q <= way_q;
      end
      if (!inv_q && !cur_line.valid) begin
        inv_q     <= 1'b1;
        inv_way_q <= way_q;
      end
      // Strictly greater keeps the lowest way on equal ages.
      if ((way_q == '0) || (age_inc > max_age_q)) begin
        max_age_q <= age_inc;
        max_way_q <= way_q;
      end
      if (way_q != way_last_q) begin
        way_q <= way_q + 1'b1;
      end
    end
    if (commit) begin
      row_q         <= row_upd;
      out_outcome_q <= outcome;
      out_way_q     <= WAY_OUT_W'(chosen);
      out_last_q    <= last_access;
      // A modify rescans the updated row for its second access.
      if (!last_access) begin
        pass_q <= 1'b1;
        way_q  <= '0;
        hit_q  <= 1'b0;
        inv_q  <= 1'b0;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.outcome        = out_outcome_q;
  assign rsp_o.way_used       = out_way_q;
  assign rsp_o.is_last        = out_last_q;
  assign rsp_o.hit_total      = hits_q;
  assign rsp_o.miss_total     = misses_q;
  assign rsp_o.eviction_total = evicts_q;

`ifndef SYNTHESIS
  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("accepted transaction did not start a set read");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (way_q <= way_last_q))
    else $error("way scan ran past the ways in use");

  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)))
    else $error("running hit or miss total went backwards");

  a_evict_needs_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evicts_q != $past(evicts_q)) |-> (misses_q != $past(misses_q)
                                       || misses_q == '1))
    else $error("eviction counted without a miss");
`endif

endmodule
